[sv/cube_map_texel_address_macros.svh]
// Assertion macros shared by the cube map texel address block.
// Depends on nothing; the including module must provide i_clk and i_rst_n.
`ifndef CUBE_MAP_TEXEL_ADDRESS_MACROS_SVH
`define CUBE_MAP_TEXEL_ADDRESS_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define CMTA_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cmta assertion failed");

// Next-cycle implication, active during reset as well.
`define CMTA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("cmta assertion failed");

`endif

[sv/cmta_pkg.sv]
// Package for the cube map texel address block: face codes, register indexes,
// fixed field widths and the control word carried along the divider chain.
// Depends on nothing.
package cmta_pkg;

    localparam int FACE_W  = 3;
    localparam int CFG_W   = 13;
    localparam int TEXEL_W = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NX = 3'd1;
    localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
    localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_FACE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FACE_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] FACE_SIZE_RESET = 13'd256;

    typedef struct packed {
        logic [FACE_W-1:0] face;
        logic              zero;
    } t_ctl;

endpackage

[sv/cmta_sel.sv]
// Front stage: major axis selection, face choice and the two dividends.
// Depends on cmta_pkg.
module cmta_sel import cmta_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [COORD_BITS-1:0] i_dir_x,
    input  logic [COORD_BITS-1:0] i_dir_y,
    input  logic [COORD_BITS-1:0] i_dir_z,
    input  logic                  i_ready_next,
    output logic                  o_ready,
    output logic                  o_valid,
    output t_ctl                  o_ctl,
    output logic [COORD_BITS:0]   o_d,
    output logic [COORD_BITS:0]   o_ru,
    output logic [COORD_BITS:0]   o_rv
);

    logic [COORD_BITS-1:0] ax, ay, az, ma, smag, tmag;
    logic                  nx, ny, nz, sneg, tneg;
    t_ctl                  n_ctl;
    logic [COORD_BITS:0]   n_ru, n_rv;
    logic                  r_valid;
    t_ctl                  r_ctl;
    logic [COORD_BITS:0]   r_d, r_ru, r_rv;

    always_comb begin
        nx = i_dir_x[COORD_BITS-1];
        ny = i_dir_y[COORD_BITS-1];
        nz = i_dir_z[COORD_BITS-1];
        ax = nx ? (~i_dir_x + 1'b1) : i_dir_x;
        ay = ny ? (~i_dir_y + 1'b1) : i_dir_y;
        az = nz ? (~i_dir_z + 1'b1) : i_dir_z;
        n_ctl.zero = (ax == '0) && (ay == '0) && (az == '0);
        if ((ax > ay) && (ax > az)) begin
            ma   = ax;
            smag = az;
            tmag = ay;
            tneg = ny;
            if (!nx) begin
                n_ctl.face = FACE_PX;
                sneg       = nz;
            end else begin
                n_ctl.face = FACE_NX;
                sneg       = !nz;
            end
        end else if (ay > az) begin
            ma   = ay;
            smag = ax;
            sneg = nx;
            tmag = az;
            if (!ny) begin
                n_ctl.face = FACE_PY;
                tneg       = nz;
            end else begin
                n_ctl.face = FACE_NY;
                tneg       = !nz;
            end
        end else begin
            ma   = az;
            smag = ax;
            tmag = ay;
            tneg = ny;
            if (!nz) begin
                n_ctl.face = FACE_PZ;
                sneg       = !nx;
            end else begin
                n_ctl.face = FACE_NZ;
                sneg       = nx;
            end
        end
        if (n_ctl.zero) begin
            n_ctl.face = FACE_NZ;
        end
        n_ru = sneg ? ({1'b0, ma} - {1'b0, smag}) : ({1'b0, ma} + {1'b0, smag});
        n_rv = tneg ? ({1'b0, ma} - {1'b0, tmag}) : ({1'b0, ma} + {1'b0, tmag});
    end

    assign o_ready = !r_valid || i_ready_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ctl <= n_ctl;
            r_d   <= {ma, 1'b0};
            r_ru  <= n_ru;
            r_rv  <= n_rv;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_d     = r_d;
    assign o_ru    = r_ru;
    assign o_rv    = r_rv;

endmodule

[sv/cmta_div_cell.sv]
// One cell of the divider chain: a restoring step for both face coordinates.
// Depends on cmta_pkg.
module cmta_div_cell import cmta_pkg::*; #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_ctl                  i_ctl,
    input  logic [COORD_BITS:0]   i_d,
    input  logic [COORD_BITS:0]   i_ru,
    input  logic [COORD_BITS:0]   i_rv,
    input  logic [FRAC_BITS-1:0]  i_qu,
    input  logic [FRAC_BITS-1:0]  i_qv,
    input  logic                  i_ready_next,
    output logic                  o_ready,
    output logic                  o_valid,
    output t_ctl                  o_ctl,
    output logic [COORD_BITS:0]   o_d,
    output logic [COORD_BITS:0]   o_ru,
    output logic [COORD_BITS:0]   o_rv,
    output logic [FRAC_BITS-1:0]  o_qu,
    output logic [FRAC_BITS-1:0]  o_qv
);

    logic                 bit_u, bit_v;
    logic [COORD_BITS:0]  rem_u, rem_v, n_ru, n_rv;
    logic [FRAC_BITS-1:0] n_qu, n_qv;
    logic                 r_valid;
    t_ctl                 r_ctl;
    logic [COORD_BITS:0]  r_d, r_ru, r_rv;
    logic [FRAC_BITS-1:0] r_qu, r_qv;

    always_comb begin
        bit_u = i_ru >= i_d;
        bit_v = i_rv >= i_d;
        rem_u = bit_u ? (i_ru - i_d) : i_ru;
        rem_v = bit_v ? (i_rv - i_d) : i_rv;
        n_ru  = {rem_u[COORD_BITS-1:0], 1'b0};
        n_rv  = {rem_v[COORD_BITS-1:0], 1'b0};
        n_qu  = {i_qu[FRAC_BITS-2:0], bit_u};
        n_qv  = {i_qv[FRAC_BITS-2:0], bit_v};
    end

    assign o_ready = !r_valid || i_ready_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ctl <= i_ctl;
            r_d   <= i_d;
            r_ru  <= n_ru;
            r_rv  <= n_rv;
            r_qu  <= n_qu;
            r_qv  <= n_qv;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_d     = r_d;
    assign o_ru    = r_ru;
    assign o_rv    = r_rv;
    assign o_qu    = r_qu;
    assign o_qv    = r_qv;

endmodule

[sv/cmta_texel.sv]
// Output stage: texel index multiply, zero vector override and output register.
// Depends on cmta_pkg.
module cmta_texel import cmta_pkg::*; #(
    parameter int FRAC_BITS     = 16,
    parameter int MAX_FACE_SIZE = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_ctl                 i_ctl,
    input  logic [FRAC_BITS-1:0] i_qu,
    input  logic [FRAC_BITS-1:0] i_qv,
    input  logic [CFG_W-1:0]     i_face_width,
    input  logic [CFG_W-1:0]     i_face_height,
    input  logic                 i_stall,
    output logic                 o_ready,
    output logic                 o_valid,
    output logic [FACE_W-1:0]    o_face,
    output logic [FRAC_BITS-1:0] o_u_frac,
    output logic [FRAC_BITS-1:0] o_v_frac,
    output logic [TEXEL_W-1:0]   o_texel_x,
    output logic [TEXEL_W-1:0]   o_texel_y,
    output logic                 o_zero_direction
);

    localparam int SIZE_CW = $clog2(MAX_FACE_SIZE + 1);
    localparam int CMP_W   = CFG_W + SIZE_CW;
    localparam int PROD_W  = FRAC_BITS + SIZE_CW + TEXEL_W;

    logic [SIZE_CW-1:0]   size_w, size_h;
    logic [PROD_W-1:0]    prod_x, prod_y;
    logic [TEXEL_W-1:0]   n_texel_x, n_texel_y;
    logic [FRAC_BITS-1:0] n_u, n_v;
    logic                 r_valid;
    t_ctl                 r_ctl;
    logic [FRAC_BITS-1:0] r_u, r_v;
    logic [TEXEL_W-1:0]   r_texel_x, r_texel_y;

    always_comb begin
        if (CMP_W'(i_face_width) > CMP_W'(MAX_FACE_SIZE)) begin
            size_w = SIZE_CW'(MAX_FACE_SIZE);
        end else begin
            size_w = SIZE_CW'(i_face_width);
        end
        if (CMP_W'(i_face_height) > CMP_W'(MAX_FACE_SIZE)) begin
            size_h = SIZE_CW'(MAX_FACE_SIZE);
        end else begin
            size_h = SIZE_CW'(i_face_height);
        end
        prod_x = PROD_W'(i_qu) * PROD_W'(size_w);
        prod_y = PROD_W'(i_qv) * PROD_W'(size_h);
        if (i_ctl.zero) begin
            n_u       = '0;
            n_v       = '0;
            n_texel_x = '0;
            n_texel_y = '0;
        end else begin
            n_u       = i_qu;
            n_v       = i_qv;
            n_texel_x = prod_x[FRAC_BITS +: TEXEL_W];
            n_texel_y = prod_y[FRAC_BITS +: TEXEL_W];
        end
    end

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ctl     <= i_ctl;
            r_u       <= n_u;
            r_v       <= n_v;
            r_texel_x <= n_texel_x;
            r_texel_y <= n_texel_y;
        end
    end

    assign o_valid          = r_valid;
    assign o_face           = r_ctl.face;
    assign o_zero_direction = r_ctl.zero;
    assign o_u_frac         = r_u;
    assign o_v_frac         = r_v;
    assign o_texel_x        = r_texel_x;
    assign o_texel_y        = r_texel_y;

endmodule

[sv/cube_map_texel_address.sv]
// Top level of the cube map texel address block: selection stage, divider
// chain of FRAC_BITS + 1 cells and texel stage. Depends on cmta_pkg and the macros header.
//
// A new direction word is taken every cycle while o_stall is low, and each
// result word passes in order through axis and face selection, one restoring
// division cell per quotient bit plus one for the integer bit that wraps 1.0
// to 0, and the texel multiply. Each stage holds its word under stall, so idle
// stages keep accepting new words while a finished result waits at the output.
// Face size registers take effect for words that reach the texel stage after the
// write.
`include "cube_map_texel_address_macros.svh"

module cube_map_texel_address import cmta_pkg::*; #(
    parameter int COORD_BITS    = 16,
    parameter int FRAC_BITS     = 16,
    parameter int MAX_FACE_SIZE = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [COORD_BITS-1:0] i_dir_x,
    input  logic [COORD_BITS-1:0] i_dir_y,
    input  logic [COORD_BITS-1:0] i_dir_z,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [FACE_W-1:0]     o_face,
    output logic [FRAC_BITS-1:0]  o_u_frac,
    output logic [FRAC_BITS-1:0]  o_v_frac,
    output logic [TEXEL_W-1:0]    o_texel_x,
    output logic [TEXEL_W-1:0]    o_texel_y,
    output logic                  o_zero_direction
);

    localparam int NCELL = FRAC_BITS + 1;

    logic [CFG_W-1:0]     r_face_width, r_face_height;
    logic                 c_valid [0:NCELL];
    t_ctl                 c_ctl   [0:NCELL];
    logic [COORD_BITS:0]  c_d     [0:NCELL];
    logic [COORD_BITS:0]  c_ru    [0:NCELL];
    logic [COORD_BITS:0]  c_rv    [0:NCELL];
    logic [FRAC_BITS-1:0] c_qu    [0:NCELL];
    logic [FRAC_BITS-1:0] c_qv    [0:NCELL];
    logic                 c_ready [0:NCELL+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_width  <= FACE_SIZE_RESET;
            r_face_height <= FACE_SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FACE_WIDTH:  r_face_width  <= i_cfg_data;
                CFG_FACE_HEIGHT: r_face_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cmta_sel #(
        .COORD_BITS (COORD_BITS)
    ) u_sel (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_dir_x      (i_dir_x),
        .i_dir_y      (i_dir_y),
        .i_dir_z      (i_dir_z),
        .i_ready_next (c_ready[1]),
        .o_ready      (c_ready[0]),
        .o_valid      (c_valid[0]),
        .o_ctl        (c_ctl[0]),
        .o_d          (c_d[0]),
        .o_ru         (c_ru[0]),
        .o_rv         (c_rv[0])
    );

    assign c_qu[0] = '0;
    assign c_qv[0] = '0;

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        cmta_div_cell #(
            .COORD_BITS (COORD_BITS),
            .FRAC_BITS  (FRAC_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_valid      (c_valid[k]),
            .i_ctl        (c_ctl[k]),
            .i_d          (c_d[k]),
            .i_ru         (c_ru[k]),
            .i_rv         (c_rv[k]),
            .i_qu         (c_qu[k]),
            .i_qv         (c_qv[k]),
            .i_ready_next (c_ready[k+2]),
            .o_ready      (c_ready[k+1]),
            .o_valid      (c_valid[k+1]),
            .o_ctl        (c_ctl[k+1]),
            .o_d          (c_d[k+1]),
            .o_ru         (c_ru[k+1]),
            .o_rv         (c_rv[k+1]),
            .o_qu         (c_qu[k+1]),
            .o_qv         (c_qv[k+1])
        );
    end

    cmta_texel #(
        .FRAC_BITS     (FRAC_BITS),
        .MAX_FACE_SIZE (MAX_FACE_SIZE)
    ) u_texel (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (c_valid[NCELL]),
        .i_ctl            (c_ctl[NCELL]),
        .i_qu             (c_qu[NCELL]),
        .i_qv             (c_qv[NCELL]),
        .i_face_width     (r_face_width),
        .i_face_height    (r_face_height),
        .i_stall          (i_stall),
        .o_ready          (c_ready[NCELL+1]),
        .o_valid          (o_valid),
        .o_face           (o_face),
        .o_u_frac         (o_u_frac),
        .o_v_frac         (o_v_frac),
        .o_texel_x        (o_texel_x),
        .o_texel_y        (o_texel_y),
        .o_zero_direction (o_zero_direction)
    );

    assign o_stall = !c_ready[0];

    // A zero vector leaves the block on the last face with a zero address.
    `CMTA_ASSERT_IMPLIES(a_zero_result, o_valid && o_zero_direction, (o_face == FACE_NZ) && (o_u_frac == '0) && (o_v_frac == '0) && (o_texel_x == '0) && (o_texel_y == '0))
    // Back-pressure reaches the input only when every stage holds a word.
    `CMTA_ASSERT_IMPLIES(a_stall_full, o_stall, o_valid && i_stall && c_valid[0] && c_valid[NCELL])
    // Reset empties the chain.
    `CMTA_ASSERT_NEXT(a_reset_empty, !i_rst_n, !o_valid && !o_stall)

endmodule

[bench/cube_map_texel_address_checker.sv]
`timescale 1ns / 1ps
// Checker for the cube map texel address block: follows the face size registers
// and both handshakes, predicts every result word and compares it field by field.
// Depends on cmta_pkg.
module cube_map_texel_address_checker import cmta_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [15:0]          i_dir_x,
    input  logic [15:0]          i_dir_y,
    input  logic [15:0]          i_dir_z,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [FACE_W-1:0]    i_face,
    input  logic [15:0]          i_u_frac,
    input  logic [15:0]          i_v_frac,
    input  logic [TEXEL_W-1:0]   i_texel_x,
    input  logic [TEXEL_W-1:0]   i_texel_y,
    input  logic                 i_zero_direction,
    output int                   o_mismatches,
    output int                   o_outstanding
);

    localparam int FRAC_BITS     = 16;
    localparam int MAX_FACE_SIZE = 4096;
    localparam int PRINT_LIMIT   = 20;

    typedef struct packed {
        logic [FACE_W-1:0]  face;
        logic [15:0]        u_frac;
        logic [15:0]        v_frac;
        logic [TEXEL_W-1:0] texel_x;
        logic [TEXEL_W-1:0] texel_y;
        logic               zero;
    } t_texel_word;

    logic [CFG_W-1:0] r_face_width  = FACE_SIZE_RESET;
    logic [CFG_W-1:0] r_face_height = FACE_SIZE_RESET;
    t_texel_word      awaited_words[$];
    int               mismatch_count = 0;
    int               awaited_count  = 0;

    assign o_mismatches  = mismatch_count;
    assign o_outstanding = awaited_count;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // The most negative component has a magnitude of 2^15; it is returned in 17 bits.
    function automatic logic [16:0] magnitude(input logic [15:0] c);
        return c[15] ? 17'h10000 - {1'b0, c} : {1'b0, c};
    endfunction

    // Truncated (ma +/- s) / (2 ma) as Q0.16; exactly 1.0 drops its integer bit.
    function automatic logic [15:0] face_fraction(input logic [16:0] ma,
                                                  input logic [16:0] side,
                                                  input logic side_neg);
        logic [63:0] num;
        logic [63:0] quo;
        num = side_neg ? 64'(ma) - 64'(side) : 64'(ma) + 64'(side);
        quo = (num << FRAC_BITS) / (64'(ma) << 1);
        return quo[15:0];
    endfunction

    function automatic logic [TEXEL_W-1:0] texel_index(input logic [15:0] frac,
                                                       input logic [CFG_W-1:0] size);
        logic [31:0] span;
        logic [31:0] prod;
        span = (size > MAX_FACE_SIZE) ? 32'(MAX_FACE_SIZE) : 32'(size);
        prod = (32'(frac) * span) >> FRAC_BITS;
        return prod[TEXEL_W-1:0];
    endfunction

    function automatic t_texel_word locate_texel(input logic [15:0] x,
                                                 input logic [15:0] y,
                                                 input logic [15:0] z);
        t_texel_word w;
        logic [16:0] ax, ay, az, ma, smag, tmag;
        logic        sneg, tneg;
        ax = magnitude(x);
        ay = magnitude(y);
        az = magnitude(z);
        w  = '0;
        if (ax == 0 && ay == 0 && az == 0) begin
            w.face = FACE_NZ;
            w.zero = 1'b1;
            return w;
        end
        // Ties go to y over x and to z over y, hence the strict comparisons.
        if (ax > ay && ax > az) begin
            ma     = ax;
            smag   = az;
            tmag   = ay;
            tneg   = y[15];
            w.face = x[15] ? FACE_NX : FACE_PX;
            sneg   = x[15] ? !z[15] : z[15];
        end else if (ay > az) begin
            ma     = ay;
            smag   = ax;
            sneg   = x[15];
            tmag   = az;
            w.face = y[15] ? FACE_NY : FACE_PY;
            tneg   = y[15] ? !z[15] : z[15];
        end else begin
            ma     = az;
            smag   = ax;
            tmag   = ay;
            tneg   = y[15];
            w.face = z[15] ? FACE_NZ : FACE_PZ;
            sneg   = z[15] ? x[15] : !x[15];
        end
        w.u_frac  = face_fraction(ma, smag, sneg);
        w.v_frac  = face_fraction(ma, tmag, tneg);
        w.texel_x = texel_index(w.u_frac, r_face_width);
        w.texel_y = texel_index(w.v_frac, r_face_height);
        return w;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_texel_word want;
        if (!i_rst_n) begin
            r_face_width  <= FACE_SIZE_RESET;
            r_face_height <= FACE_SIZE_RESET;
            awaited_words.delete();
            awaited_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FACE_WIDTH: begin
                        r_face_width <= i_cfg_data;
                    end
                    CFG_FACE_HEIGHT: begin
                        r_face_height <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (awaited_words.size() == 0) begin
                    report_mismatch("result word with none expected", 0, 0);
                end else begin
                    want = awaited_words.pop_front();
                    if (i_face !== want.face)
                        report_mismatch("face", i_face, want.face);
                    if (i_u_frac !== want.u_frac)
                        report_mismatch("u_frac", i_u_frac, want.u_frac);
                    if (i_v_frac !== want.v_frac)
                        report_mismatch("v_frac", i_v_frac, want.v_frac);
                    if (i_texel_x !== want.texel_x)
                        report_mismatch("texel_x", i_texel_x, want.texel_x);
                    if (i_texel_y !== want.texel_y)
                        report_mismatch("texel_y", i_texel_y, want.texel_y);
                    if (i_zero_direction !== want.zero)
                        report_mismatch("zero_direction", i_zero_direction, want.zero);
                end
            end
            if (i_in_valid && !i_in_stall)
                awaited_words.push_back(locate_texel(i_dir_x, i_dir_y, i_dir_z));
            awaited_count = awaited_words.size();
        end
    end

endmodule

[bench/tb_cube_map_texel_address.sv]
`timescale 1ns / 1ps
// Testbench top for cube_map_texel_address: clock, reset, face size writes and
// directed then random direction words under bursty input and a stalling output.
// Depends on cmta_pkg, the block itself and cube_map_texel_address_checker.
module tb_cube_map_texel_address;
    import cmta_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int SETTLE_LIMIT = 20000;
    localparam int RANDOM_WORDS = 185;
    localparam logic [4:0][15:0] CORNERS =
        {16'h0000, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF};

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_FACE_WIDTH;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 i_valid     = 1'b0;
    logic [15:0]          i_dir_x     = '0;
    logic [15:0]          i_dir_y     = '0;
    logic [15:0]          i_dir_z     = '0;
    logic                 i_stall     = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic [FACE_W-1:0]    o_face;
    logic [15:0]          o_u_frac;
    logic [15:0]          o_v_frac;
    logic [TEXEL_W-1:0]   o_texel_x;
    logic [TEXEL_W-1:0]   o_texel_y;
    logic                 o_zero_direction;
    int                   mismatches;
    int                   outstanding;
    int                   burst_left = 0;
    bit                   word_held  = 1'b0;
    int                   stall_run  = 0;
    int                   stall_mode = 0;

    cube_map_texel_address uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_dir_x          (i_dir_x),
        .i_dir_y          (i_dir_y),
        .i_dir_z          (i_dir_z),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_face           (o_face),
        .o_u_frac         (o_u_frac),
        .o_v_frac         (o_v_frac),
        .o_texel_x        (o_texel_x),
        .o_texel_y        (o_texel_y),
        .o_zero_direction (o_zero_direction)
    );

    cube_map_texel_address_checker texel_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_dir_x          (i_dir_x),
        .i_dir_y          (i_dir_y),
        .i_dir_z          (i_dir_z),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_face           (o_face),
        .i_u_frac         (o_u_frac),
        .i_v_frac         (o_v_frac),
        .i_texel_x        (o_texel_x),
        .i_texel_y        (o_texel_y),
        .i_zero_direction (o_zero_direction),
        .o_mismatches     (mismatches),
        .o_outstanding    (outstanding)
    );

    always #5 i_clk = ~i_clk;

    // The output stalls in stretches: none, light, heavy or solid.
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_run  = $urandom_range(5, 60);
        end else begin
            stall_run--;
        end
        case (stall_mode)
            0: begin
                i_stall <= 1'b0;
            end
            1: begin
                i_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
                i_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                i_stall <= 1'b1;
            end
        endcase
    end

    task automatic push_direction(input logic [15:0] x, input logic [15:0] y,
                                  input logic [15:0] z);
        int gap;
        i_valid   <= 1'b1;
        i_dir_x   <= x;
        i_dir_y   <= y;
        i_dir_z   <= z;
        word_held = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid   <= 1'b0;
            word_held = 1'b0;
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                      : $urandom_range(0, 12);
        end
    endtask

    task automatic settle_words();
        int waited;
        if (word_held) begin
            i_valid   <= 1'b0;
            word_held = 1'b0;
        end
        waited = 0;
        @(posedge i_clk);
        while (outstanding != 0 && waited < SETTLE_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    task automatic set_face_size(input logic [CFG_W-1:0] width,
                                 input logic [CFG_W-1:0] height);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_FACE_WIDTH;
        i_cfg_data  <= width;
        @(posedge i_clk);
        i_cfg_index <= CFG_FACE_HEIGHT;
        i_cfg_data  <= height;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Most words are plain random; the rest aim at ties, wraps and corners.
    task automatic pick_direction(output logic [15:0] x, output logic [15:0] y,
                                  output logic [15:0] z);
        logic [15:0] c [3];
        logic [15:0] m;
        int          lead;
        for (int k = 0; k < 3; k++) c[k] = 16'($urandom);
        m    = 16'($urandom_range(1, 32767));
        lead = $urandom_range(0, 2);
        case ($urandom_range(0, 9))
            5: begin
                for (int k = 0; k < 3; k++) c[k] = 16'($urandom_range(0, 6)) - 16'd3;
            end
            6: begin
                for (int k = 0; k < 3; k++)
                    if ($urandom_range(0, 3) != 0) c[k] = $urandom_range(0, 1) ? -m : m;
            end
            7: begin
                c[lead] = $urandom_range(0, 1) ? -m : m;
                for (int k = 0; k < 3; k++) begin
                    if (k != lead) begin
                        case ($urandom_range(0, 3))
                            0: begin
                                c[k] = m;
                            end
                            1: begin
                                c[k] = -m;
                            end
                            2: begin
                                c[k] = $urandom_range(0, 1) ? -(m - 16'd1) : m - 16'd1;
                            end
                            default: begin
                                c[k] = 16'($urandom_range(0, 32'(m)));
                            end
                        endcase
                    end
                end
            end
            8: begin
                for (int k = 0; k < 3; k++) c[k] = CORNERS[$urandom_range(0, 4)];
            end
            default: begin
            end
        endcase
        x = c[0];
        y = c[1];
        z = c[2];
    endtask

    initial begin : stimulus
        logic [15:0] x, y, z;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words at the reset face size.
        push_direction(16'h0000, 16'h0000, 16'h0000);
        push_direction(16'h7FFF, 16'h0000, 16'h0000);
        push_direction(16'h8000, 16'h0000, 16'h0000);
        push_direction(16'h0000, 16'h7FFF, 16'h0000);
        push_direction(16'h0000, 16'h8000, 16'h0000);
        push_direction(16'h0000, 16'h0000, 16'h7FFF);
        push_direction(16'h0000, 16'h0000, 16'h8000);
        push_direction(16'h03E8, 16'h03E8, 16'h0005);
        push_direction(16'h0005, 16'hFC18, 16'h03E8);
        push_direction(16'h1B58, 16'h0003, 16'hE4A8);
        push_direction(16'h8000, 16'h8000, 16'h8000);
        push_direction(16'h8AD0, 16'h7530, 16'h7530);
        push_direction(16'h7FFF, 16'h7FFF, 16'h8000);
        push_direction(16'h8000, 16'h7FFF, 16'h7FFF);
        push_direction(16'h7FFF, 16'h8000, 16'h0000);
        push_direction(16'h0001, 16'h0000, 16'h0000);
        push_direction(16'h0000, 16'h0000, 16'hFFFF);
        push_direction(16'hFFFF, 16'h0001, 16'hFFFF);
        push_direction(16'h0001, 16'hFFFF, 16'h0000);
        push_direction(16'h7FFF, 16'h7FFF, 16'h7FFF);
        push_direction(16'h5555, 16'hAAAA, 16'h0F0F);
        push_direction(16'hAAAA, 16'h5555, 16'hF0F0);
        push_direction(16'h4000, 16'hC000, 16'h7FFF);

        for (int p = 0; p < 10; p++) begin
            if (p > 0) begin
                settle_words();
                case (p)
                    1: begin
                        set_face_size(13'd1, 13'd1);
                    end
                    2: begin
                        set_face_size(13'd4096, 13'd4096);
                    end
                    3: begin
                        set_face_size(13'd0, 13'd8191);
                    end
                    4: begin
                        set_face_size(13'd8191, 13'd0);
                    end
                    5: begin
                        set_face_size(13'd4097, 13'd1);
                    end
                    6: begin
                        set_face_size(13'd1, 13'd4096);
                    end
                    7: begin
                        set_face_size(13'd37, 13'd640);
                    end
                    default: begin
                        set_face_size(13'($urandom_range(1, 4096)),
                                      13'($urandom_range(1, 4096)));
                    end
                endcase
            end
            repeat (RANDOM_WORDS) begin
                pick_direction(x, y, z);
                push_direction(x, y, z);
            end
        end

        settle_words();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_cube_map_texel_address OK");
        end else begin
            $display("tb_cube_map_texel_address NOT OK");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("tb_cube_map_texel_address NOT OK");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/cmta_pkg.sv
sv/cmta_sel.sv
sv/cmta_div_cell.sv
sv/cmta_texel.sv
sv/cube_map_texel_address.sv
bench/cube_map_texel_address_checker.sv
bench/tb_cube_map_texel_address.sv
